/* hdl/i2cmbe_pkg.sv */
// Shared types and codes for the I2C master byte engine.
// Used by i2cmbe_core, the top level and the port checker; no dependencies.
package i2cmbe_pkg;

    // Command codes carried by a request
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    // Status codes reported with each result
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_SCL_LOW      = 3'd1;
    localparam logic [2:0] ST_SDA_LOW      = 3'd2;
    localparam logic [2:0] ST_BIT_MISMATCH = 3'd3;
    localparam logic [2:0] ST_ACK_MISMATCH = 3'd4;

    // Bus phase numbers within a command
    localparam logic [2:0] PH0 = 3'd0;
    localparam logic [2:0] PH1 = 3'd1;
    localparam logic [2:0] PH2 = 3'd2;
    localparam logic [2:0] PH3 = 3'd3;
    localparam logic [2:0] PH4 = 3'd4;
    localparam logic [2:0] PH5 = 3'd5;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam logic [15:0] TICK_MAX          = 16'hFFFF;
    localparam logic [2:0]  BIT_LAST          = 3'd7;

    // Active operation, one-hot
    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_WRITE = 5'b00100,
        OP_READ  = 5'b01000,
        OP_STOP  = 5'b10000
    } op_t;

    // One request: command plus the sensed line levels of this tick
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       scl_level;
        logic       sda_level;
    } req_t;

    // One result per tick
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] rx_byte;
        logic       ack_bit;
    } rsp_t;

endpackage

/* hdl/i2cmbe_core.sv */
// Bus sequencer of the I2C master byte engine: per-tick phase timing,
// line drive, bit checks and sampling. Depends on i2cmbe_pkg.
module i2cmbe_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  i2cmbe_pkg::req_t   req,
    input  logic [15:0]        half_period,
    output i2cmbe_pkg::rsp_t   rsp
);
    import i2cmbe_pkg::*;

    op_t         op_reg,     op_next;
    logic [2:0]  phase_reg,  phase_next;
    logic [2:0]  bits_reg,   bits_next;
    logic [15:0] tick_reg,   tick_next;
    logic [7:0]  shift_reg,  shift_next;
    logic        scl_drv_reg, scl_drv_next;
    logic        sda_drv_reg, sda_drv_next;
    logic [2:0]  status_reg, status_next;
    logic        ack_req_reg, ack_req_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic        ack_hold_reg, ack_hold_next;

    logic [15:0] tick_inc;
    logic        enter;
    logic        done;
    logic        fin_done;
    logic [2:0]  fin_err;

    // Saturating tick counter
    assign tick_inc = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 16'd1;

    // Phase end, new command and phase entry
    always_comb
    begin
        op_next       = op_reg;
        phase_next    = phase_reg;
        bits_next     = bits_reg;
        tick_next     = tick_reg;
        shift_next    = shift_reg;
        status_next   = status_reg;
        ack_req_next  = ack_req_reg;
        rx_hold_next  = rx_hold_reg;
        ack_hold_next = ack_hold_reg;
        scl_drv_next  = scl_drv_reg;
        sda_drv_next  = sda_drv_reg;
        enter         = 1'b0;
        done          = 1'b0;
        fin_done      = 1'b0;
        fin_err       = ST_OK;

        if (op_reg != OP_IDLE) begin
            tick_next = tick_inc;
            if (tick_inc >= half_period) begin
                tick_next = '0;
                case (op_reg)
                    OP_START, OP_STOP:
                    begin
                        if (phase_reg == PH2) begin
                            if (!req.scl_level) begin
                                fin_done = 1'b1;
                                fin_err  = ST_SCL_LOW;
                            end else if (!req.sda_level) begin
                                fin_done = 1'b1;
                                fin_err  = ST_SDA_LOW;
                            end else if (op_reg == OP_STOP) begin
                                fin_done = 1'b1;
                            end else begin
                                phase_next = PH3;
                            end
                        end else if (op_reg == OP_START && phase_reg >= PH4) begin
                            fin_done = 1'b1;
                        end else begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                    OP_WRITE, OP_READ:
                    begin
                        if (phase_reg == PH1) begin
                            // SCL high: check or sample the data bit
                            if (!req.scl_level) begin
                                fin_done = 1'b1;
                                fin_err  = ST_SCL_LOW;
                            end else if (op_reg == OP_WRITE) begin
                                if (req.sda_level != shift_reg[7]) begin
                                    fin_done = 1'b1;
                                    fin_err  = ST_BIT_MISMATCH;
                                end else begin
                                    phase_next = PH2;
                                end
                            end else begin
                                shift_next = {shift_reg[6:0], req.sda_level};
                                phase_next = PH2;
                            end
                        end else if (phase_reg == PH2) begin
                            if (bits_reg == '0) begin
                                phase_next = PH3;
                            end else begin
                                bits_next  = bits_reg - 3'd1;
                                phase_next = PH0;
                                if (op_reg == OP_WRITE)
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                end
                            end
                        end else if (phase_reg == PH4) begin
                            // ack slot
                            if (op_reg == OP_WRITE) begin
                                ack_hold_next = req.sda_level;
                                phase_next    = PH5;
                            end else if (req.sda_level != ack_req_reg) begin
                                fin_done = 1'b1;
                                fin_err  = ST_ACK_MISMATCH;
                            end else begin
                                phase_next = PH5;
                            end
                        end else if (phase_reg >= PH5) begin
                            if (op_reg == OP_READ)
                            begin
                                rx_hold_next = shift_reg;
                            end
                            fin_done = 1'b1;
                        end else begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        fin_done = 1'b1;
                    end
                endcase

                if (fin_done) begin
                    status_next = fin_err;
                    op_next     = OP_IDLE;
                    phase_next  = PH0;
                    done        = 1'b1;
                end else begin
                    enter = 1'b1;
                end
            end
        end else if (req.command >= CMD_START && req.command <= CMD_STOP) begin
            case (req.command)
                CMD_START: op_next = OP_START;
                CMD_WRITE: op_next = OP_WRITE;
                CMD_READ:  op_next = OP_READ;
                CMD_STOP:  op_next = OP_STOP;
                default:   op_next = OP_IDLE;
            endcase
            phase_next   = PH0;
            bits_next    = BIT_LAST;
            tick_next    = '0;
            shift_next   = (req.command == CMD_WRITE) ? req.tx_byte : 8'd0;
            ack_req_next = req.ack_level;
            status_next  = ST_OK;
            enter        = 1'b1;
        end

        // Line drive at the first tick of a phase
        if (enter) begin
            case (op_next)
                OP_START:
                begin
                    if (phase_next == PH0 || phase_next == PH4) scl_drv_next = 1'b1;
                    else if (phase_next == PH1)                 sda_drv_next = 1'b0;
                    else if (phase_next == PH2)                 scl_drv_next = 1'b0;
                    else                                        sda_drv_next = 1'b1;
                end
                OP_WRITE, OP_READ:
                begin
                    if (phase_next == PH0) begin
                        sda_drv_next = (op_next == OP_WRITE) ? !shift_next[7] : 1'b0;
                    end else if (phase_next == PH1 || phase_next == PH4) begin
                        scl_drv_next = 1'b0;
                    end else if (phase_next == PH2 || phase_next == PH5) begin
                        scl_drv_next = 1'b1;
                    end else begin
                        sda_drv_next = (op_next == OP_WRITE) ? 1'b0 : !ack_req_next;
                    end
                end
                OP_STOP:
                begin
                    if (phase_next == PH0)      sda_drv_next = 1'b1;
                    else if (phase_next == PH1) scl_drv_next = 1'b0;
                    else                        sda_drv_next = 1'b0;
                end
                default:
                begin
                    scl_drv_next = scl_drv_reg;
                end
            endcase
        end
    end

    // Result of this tick, from the updated state
    always_comb
    begin
        rsp.scl_pull_low = scl_drv_next;
        rsp.sda_pull_low = sda_drv_next;
        rsp.busy_res     = (op_next != OP_IDLE);
        rsp.done_res     = done;
        rsp.status       = status_next;
        rsp.rx_byte      = rx_hold_next;
        rsp.ack_bit      = ack_hold_next;
    end

    // State registers, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op_reg       <= OP_IDLE;
            phase_reg    <= PH0;
            bits_reg     <= '0;
            tick_reg     <= '0;
            shift_reg    <= '0;
            scl_drv_reg  <= 1'b0;
            sda_drv_reg  <= 1'b0;
            status_reg   <= ST_OK;
            ack_req_reg  <= 1'b0;
            rx_hold_reg  <= '0;
            ack_hold_reg <= 1'b0;
        end else if (step) begin
            op_reg       <= op_next;
            phase_reg    <= phase_next;
            bits_reg     <= bits_next;
            tick_reg     <= tick_next;
            shift_reg    <= shift_next;
            scl_drv_reg  <= scl_drv_next;
            sda_drv_reg  <= sda_drv_next;
            status_reg   <= status_next;
            ack_req_reg  <= ack_req_next;
            rx_hold_reg  <= rx_hold_next;
            ack_hold_reg <= ack_hold_next;
        end
    end

endmodule

/* hdl/i2c_master_byte_engine_unit.sv */
// Top level of the I2C master byte engine: request/result handshake,
// half_period register and result register. Depends on i2cmbe_pkg, i2cmbe_core.
// Latency: the result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the result side is not stalled; the single
// result register is refilled in the same cycle it is emptied.
// Reset (rst_n low, asynchronous): idle, lines released, half_period 250.
module i2c_master_byte_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  i2cmbe_pkg::req_t   cmd_req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output i2cmbe_pkg::rsp_t   rsp,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);
    import i2cmbe_pkg::*;

    logic [15:0] half_period_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    rsp_t        core_rsp;
    logic        step;

    // Accept while the result register is empty or being drained
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign step      = cmd_valid && cmd_ready;

    i2cmbe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .req         (cmd_req),
        .half_period (half_period_reg),
        .rsp         (core_rsp)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_we) begin
            half_period_reg <= cfg_data;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else if (step) begin
            rsp_valid_reg <= 1'b1;
        end else if (rsp_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (step) begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hdl/i2cmbe_checker.sv */
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_unit.
module i2cmbe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input i2cmbe_pkg::rsp_t   rsp
);
    import i2cmbe_pkg::*;

    // A finished command never reports busy on its done tick
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.done_res |-> !rsp.busy_res)
        else $error("done_res with busy_res set");

    // An empty result register always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("request stalled with empty result register");

    // An accepted request always yields a result next cycle
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("accepted request produced no result");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_i2cmbe_checker (.*);

/* tb/sv/i2c_master_byte_engine_unit_test.sv */
// Self-checking bench for the I2C master byte engine top level.
// It models the open-drain bus, predicts every per-tick result and compares it.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_unit.
module i2c_master_byte_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbe_pkg::*;

    localparam int PHASE_END      = -1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int SEGMENTS       = 4;

    // How the bench disturbs the sensed lines during a command
    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_SCL_LOW,
        FAULT_SDA_LOW,
        FAULT_SDA_FLIP
    } fault_t;

    logic   clk;
    logic   rst_n;
    logic   cmd_valid;
    logic   cmd_ready;
    req_t   cmd_req;
    logic   rsp_valid;
    logic   rsp_ready;
    rsp_t   rsp;
    logic        cfg_we;
    logic [15:0] cfg_data;

    // Predicted engine state
    logic [15:0] m_half;
    logic [2:0]  m_op;
    logic [4:0]  m_phase;
    logic [2:0]  m_bits;
    logic [15:0] m_ticks;
    logic [7:0]  m_shift;
    logic        m_scl_low;
    logic        m_sda_low;
    logic [2:0]  m_status;
    logic        m_ack_req;
    logic [7:0]  m_rx;
    logic        m_ack_seen;

    // Bus and slave behavior
    fault_t     fault;
    int         noise_pct;
    logic [7:0] slave_byte;
    logic       slave_nack;

    rsp_t tick_results[$];
    int   n_errors;
    int   n_ticks;
    int   quiet_cycles;
    int   long_hold;
    bit   idle_en;

    i2c_master_byte_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_req   (cmd_req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Engine predictor
    // ---------------------------------------------------------------

    // Line drive applied at the first tick of a phase
    function automatic void drive_for_phase();
        case (m_op)
            CMD_START:
            begin
                if (m_phase == PH0 || m_phase == PH4) m_scl_low = 1'b1;
                else if (m_phase == PH1) m_sda_low = 1'b0;
                else if (m_phase == PH2) m_scl_low = 1'b0;
                else m_sda_low = 1'b1;
            end
            CMD_WRITE, CMD_READ:
            begin
                if (m_phase == PH0)
                    m_sda_low = (m_op == CMD_WRITE) ? !m_shift[7] : 1'b0;
                else if (m_phase == PH1 || m_phase == PH4) m_scl_low = 1'b0;
                else if (m_phase == PH2 || m_phase == PH5) m_scl_low = 1'b1;
                else m_sda_low = (m_op == CMD_WRITE) ? 1'b0 : !m_ack_req;
            end
            CMD_STOP:
            begin
                if (m_phase == PH0) m_sda_low = 1'b1;
                else if (m_phase == PH1) m_scl_low = 1'b0;
                else m_sda_low = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Checks and samples at the last tick of a phase; gives the next phase
    function automatic int close_phase(input logic scl, input logic sda,
                                       output logic [2:0] err);
        err = ST_OK;
        case (m_op)
            CMD_START, CMD_STOP:
            begin
                if (m_phase == PH2)
                begin
                    if (!scl)
                    begin
                        err = ST_SCL_LOW;
                        return PHASE_END;
                    end
                    if (!sda)
                    begin
                        err = ST_SDA_LOW;
                        return PHASE_END;
                    end
                    return (m_op == CMD_STOP) ? PHASE_END : int'(PH3);
                end
                if (m_op == CMD_START && m_phase >= PH4) return PHASE_END;
                return m_phase + 1;
            end
            CMD_WRITE, CMD_READ:
            begin
                if (m_phase == PH1)
                begin
                    if (!scl)
                    begin
                        err = ST_SCL_LOW;
                        return PHASE_END;
                    end
                    if (m_op == CMD_WRITE)
                    begin
                        if (sda != m_shift[7])
                        begin
                            err = ST_BIT_MISMATCH;
                            return PHASE_END;
                        end
                    end
                    else
                        m_shift = {m_shift[6:0], sda};
                    return int'(PH2);
                end
                if (m_phase == PH2)
                begin
                    if (m_bits == 3'd0) return int'(PH3);
                    m_bits = m_bits - 3'd1;
                    if (m_op == CMD_WRITE) m_shift = m_shift << 1;
                    return int'(PH0);
                end
                if (m_phase == PH4)
                begin
                    if (m_op == CMD_WRITE)
                        m_ack_seen = sda;
                    else if (sda != m_ack_req)
                    begin
                        err = ST_ACK_MISMATCH;
                        return PHASE_END;
                    end
                    return int'(PH5);
                end
                if (m_phase >= PH5)
                begin
                    if (m_op == CMD_READ) m_rx = m_shift;
                    return PHASE_END;
                end
                return m_phase + 1;
            end
            default: return PHASE_END;
        endcase
    endfunction

    // One system tick: advance the engine and form the result it reports
    function automatic rsp_t step_engine(input req_t r);
        rsp_t       o;
        int         nxt;
        logic [2:0] err;
        logic       fin;
        fin = 1'b0;
        if (m_op != CMD_NONE)
        begin
            if (m_ticks < TICK_MAX) m_ticks = m_ticks + 16'd1;
            if (m_ticks >= m_half)
            begin
                nxt = close_phase(r.scl_level, r.sda_level, err);
                m_ticks = '0;
                if (nxt == PHASE_END)
                begin
                    m_status = err;
                    m_op     = CMD_NONE;
                    m_phase  = '0;
                    fin      = 1'b1;
                end
                else
                begin
                    m_phase = 5'(nxt);
                    drive_for_phase();
                end
            end
        end
        else if (r.command >= CMD_START && r.command <= CMD_STOP)
        begin
            m_op      = r.command;
            m_phase   = '0;
            m_bits    = BIT_LAST;
            m_ticks   = '0;
            m_shift   = (r.command == CMD_WRITE) ? r.tx_byte : 8'h00;
            m_ack_req = r.ack_level;
            m_status  = ST_OK;
            drive_for_phase();
        end
        o.scl_pull_low = m_scl_low;
        o.sda_pull_low = m_sda_low;
        o.busy_res     = (m_op != CMD_NONE);
        o.done_res     = fin;
        o.status       = m_status;
        o.rx_byte      = m_rx;
        o.ack_bit      = m_ack_seen;
        return o;
    endfunction

    task automatic reset_model();
        m_half     = HALF_PERIOD_RESET;
        m_op       = CMD_NONE;
        m_phase    = '0;
        m_bits     = '0;
        m_ticks    = '0;
        m_shift    = '0;
        m_scl_low  = 1'b0;
        m_sda_low  = 1'b0;
        m_status   = ST_OK;
        m_ack_req  = 1'b0;
        m_rx       = '0;
        m_ack_seen = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Bus model: open-drain lines, slave answers, injected faults
    // ---------------------------------------------------------------
    function automatic req_t bus_req(input logic [2:0] cmd, input logic [7:0] tx,
                                     input logic ackl);
        req_t r;
        logic slave_sda;
        slave_sda = 1'b1;
        if (m_op == CMD_READ && m_phase == PH1) slave_sda = slave_byte[m_bits];
        else if (m_op == CMD_WRITE && m_phase == PH4) slave_sda = slave_nack;
        r.command   = cmd;
        r.tx_byte   = tx;
        r.ack_level = ackl;
        r.scl_level = !m_scl_low;
        r.sda_level = !m_sda_low && slave_sda;
        case (fault)
            FAULT_SCL_LOW:  r.scl_level = 1'b0;
            FAULT_SDA_LOW:  r.sda_level = 1'b0;
            FAULT_SDA_FLIP: r.sda_level = !r.sda_level;
            default: ;
        endcase
        if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
        begin
            r.scl_level = 1'($urandom);
            r.sda_level = 1'($urandom);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // Offer one request, wait for acceptance, record the predicted result
    task automatic send_tick(input req_t r);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_req   <= r;
        do @(posedge clk); while (!cmd_ready);
        tick_results.push_back(step_engine(r));
        n_ticks++;
    endtask

    // Issue a command and keep the bus ticking until the engine is idle;
    // requests made while busy carry random commands that must be ignored
    task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] tx, input logic ackl);
        send_tick(bus_req(cmd, tx, ackl));
        while (m_op != CMD_NONE)
            send_tick(bus_req(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom)));
    endtask

    // Stop requesting and wait until every predicted result has arrived
    task automatic hold_requests();
        @(negedge clk);
        cmd_valid <= 1'b0;
        wait (tick_results.size() == 0);
    endtask

    // Write half_period while nothing is in flight
    task automatic set_half(input logic [15:0] v);
        hold_requests();
        repeat (2) @(negedge clk);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        m_half = v;
    endtask

    // One transaction: up to two ignored commands, start, a few byte transfers, stop; rare faults and noise
    task automatic random_transaction();
        int         k;
        logic [2:0] cmd;
        repeat ($urandom_range(0, 2))
        begin
            k = $urandom_range(0, 3);
            cmd = (k == 0) ? CMD_NONE : CMD_STOP + 3'(k);
            run_cmd(cmd, 8'($urandom), 1'($urandom));
        end
        for (int i = 0; i < $urandom_range(3, 5); i++)
        begin
            if (i == 0) cmd = CMD_START;
            else if (i == 4) cmd = CMD_STOP;
            else cmd = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ;
            slave_byte = 8'($urandom);
            slave_nack = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            if (k < 2) fault = FAULT_SCL_LOW;
            else if (k < 4) fault = FAULT_SDA_LOW;
            else if (k < 6) fault = FAULT_SDA_FLIP;
            else fault = FAULT_NONE;
            noise_pct = ($urandom_range(0, 9) == 0) ? 3 : 0;
            run_cmd(cmd, 8'($urandom), 1'($urandom));
        end
        fault = FAULT_NONE;
        noise_pct = 0;
        run_cmd(CMD_STOP, 8'($urandom), 1'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Test tasks
    // ---------------------------------------------------------------

    // Reset half_period of 250 ticks: a write whose first bit sees SCL held low
    task automatic test_reset_period();
        fault = FAULT_SCL_LOW;
        run_cmd(CMD_WRITE, 8'hA5, 1'b0);
        fault = FAULT_NONE;
    endtask

    // Zero half_period behaves like one tick per phase
    task automatic test_zero_period();
        set_half(16'd0);
        run_cmd(CMD_START, 8'h00, 1'b0);
        slave_nack = 1'b0;
        run_cmd(CMD_WRITE, 8'h3C, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_write_bytes();
        set_half(16'd1);
        run_cmd(CMD_START, 8'h00, 1'b0);
        slave_nack = 1'b0;
        run_cmd(CMD_WRITE, 8'h00, 1'b1);
        slave_nack = 1'b1;
        run_cmd(CMD_WRITE, 8'hFF, 1'b0);
        slave_nack = 1'b0;
        run_cmd(CMD_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_read_bytes();
        run_cmd(CMD_START, 8'h00, 1'b0);
        slave_byte = 8'hFF;
        run_cmd(CMD_READ, 8'h00, 1'b0);
        slave_byte = 8'h00;
        run_cmd(CMD_READ, 8'hFF, 1'b1);
        slave_byte = 8'h5A;
        run_cmd(CMD_READ, 8'hA5, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0);
    endtask

    // No-op and unused command codes while idle
    task automatic test_ignored_commands();
        for (int k = 0; k < 4; k++)
            run_cmd((k == 0) ? CMD_NONE : CMD_STOP + 3'(k), 8'($urandom), 1'($urandom));
    endtask

    // Every error status; lines stay as driven, rx_byte and ack_bit are kept
    task automatic test_bus_errors();
        fault = FAULT_SCL_LOW;
        run_cmd(CMD_START, 8'h00, 1'b0);
        fault = FAULT_SDA_LOW;
        run_cmd(CMD_START, 8'h00, 1'b0);
        fault = FAULT_SCL_LOW;
        run_cmd(CMD_STOP, 8'h00, 1'b0);
        fault = FAULT_SDA_LOW;
        run_cmd(CMD_STOP, 8'h00, 1'b0);
        fault = FAULT_SDA_FLIP;
        run_cmd(CMD_WRITE, 8'h55, 1'b0);
        fault = FAULT_SCL_LOW;
        run_cmd(CMD_WRITE, 8'hAA, 1'b0);
        fault = FAULT_SDA_FLIP;
        run_cmd(CMD_READ, 8'h00, 1'b0);
        fault = FAULT_SCL_LOW;
        run_cmd(CMD_READ, 8'h00, 1'b1);
        fault = FAULT_NONE;
        run_cmd(CMD_STOP, 8'h00, 1'b0);
    endtask

    // Long half_period: a write that fails on its first bit
    task automatic test_long_period();
        set_half(16'd40);
        idle_en = 1'b0;
        fault = FAULT_SDA_FLIP;
        run_cmd(CMD_WRITE, 8'h80, 1'b0);
        fault = FAULT_NONE;
        idle_en = 1'b1;
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_half(16'd1);
        idle_en = 1'b0;
        long_hold = 80;
        random_transaction();
        random_transaction();
        idle_en = 1'b1;
    endtask

    // Random transactions over several half_period settings
    task automatic test_random_traffic();
        int seg_start;
        bit paused;
        paused = 1'b0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: set_half(16'd1);
                1: set_half(16'd2);
                2: set_half(16'($urandom_range(1, 3)));
                default: set_half(16'd1);
            endcase
            if (seg == SEGMENTS - 1) idle_en = 1'b0;
            seg_start = n_ticks;
            while (n_ticks - seg_start < RANDOM_ITEMS / SEGMENTS)
            begin
                random_transaction();
                // sender pauses once until all results are in
                if (seg == 2 && !paused)
                begin
                    hold_requests();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls and one long hold-off
    // ---------------------------------------------------------------
    initial
    begin : rsp_side
        int stall;
        stall = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                rsp_ready <= 1'b0;
                long_hold--;
            end
            else if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                rsp_ready <= 1'b0;
                stall = $urandom_range(0, 16);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic cmp_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (tick_results.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, expected none actual %h",
                         $time, rsp);
                n_errors++;
            end
            else
            begin
                want = tick_results.pop_front();
                cmp_field("scl_pull_low", 8'(want.scl_pull_low), 8'(rsp.scl_pull_low));
                cmp_field("sda_pull_low", 8'(want.sda_pull_low), 8'(rsp.sda_pull_low));
                cmp_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
                cmp_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
                cmp_field("status", 8'(want.status), 8'(rsp.status));
                cmp_field("rx_byte", want.rx_byte, rsp.rx_byte);
                cmp_field("ack_bit", 8'(want.ack_bit), 8'(rsp.ack_bit));
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[i2c_master_byte_engine_unit] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_req      = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        n_errors     = 0;
        n_ticks      = 0;
        quiet_cycles = 0;
        long_hold    = 0;
        idle_en      = 1'b1;
        fault        = FAULT_NONE;
        noise_pct    = 0;
        slave_byte   = '0;
        slave_nack   = 1'b0;
        reset_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_period();
        test_zero_period();
        test_write_bytes();
        test_read_bytes();
        test_ignored_commands();
        test_bus_errors();
        test_long_period();
        test_backpressure();
        test_random_traffic();

        hold_requests();
        repeat (4) @(posedge clk);
        if (n_errors == 0)
            $display("[i2c_master_byte_engine_unit] OK");
        else
            $display("[i2c_master_byte_engine_unit] ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_core.sv
hdl/i2c_master_byte_engine_unit.sv
hdl/i2cmbe_checker.sv
tb/sv/i2c_master_byte_engine_unit_test.sv
